FILE: hw/rtl/wca_pkg.sv
package wca_pkg;

  localparam int HOLDERS_PER_CLASS = 16;

  localparam int ID_W   = 16;
  localparam int CRED_W = 8;
  localparam int CMD_W  = 3;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REVOKE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HALT    = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_CREDIT_LIMIT = 2'd0;
  localparam logic [1:0] REG_WEIGHT_A     = 2'd1;
  localparam logic [1:0] REG_WEIGHT_B     = 2'd2;

  // operations on a holder row
  localparam logic [2:0] CH_HOLD   = 3'd0;
  localparam logic [2:0] CH_APPEND = 3'd1;
  localparam logic [2:0] CH_REMOVE = 3'd2;
  localparam logic [2:0] CH_POP    = 3'd3;
  localparam logic [2:0] CH_CLEAR  = 3'd4;

  // operations on one slot
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_TAKE  = 2'd2;
  localparam logic [1:0] CELL_CLEAR = 2'd3;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] key;
  } chain_ctl_t;

endpackage

FILE: hw/rtl/wca_cell.sv
module wca_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                op,
  input  logic [wca_pkg::ID_W-1:0]  key,
  input  logic [wca_pkg::ID_W-1:0]  right_id,
  input  logic                      right_valid,
  output logic [wca_pkg::ID_W-1:0]  id,
  output logic                      valid,
  output logic                      hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        wca_pkg::CELL_LOAD:  valid <= 1'b1;
        wca_pkg::CELL_TAKE:  valid <= right_valid;
        wca_pkg::CELL_CLEAR: valid <= 1'b0;
        default:             valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      wca_pkg::CELL_LOAD: id <= key;
      wca_pkg::CELL_TAKE: id <= right_id;
      default:            id <= id;
    endcase
  end

  assign hit = valid && (id == key);

endmodule

FILE: hw/rtl/wca_chain.sv
module wca_chain #(
  parameter int N = wca_pkg::HOLDERS_PER_CLASS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wca_pkg::chain_ctl_t          ctl,
  output logic [$clog2(N+1)-1:0]       count,
  output logic                         found,
  output logic [wca_pkg::ID_W-1:0]     head_id
);

  localparam int CW = $clog2(N+1);
  localparam int LG = $clog2(N);

  logic [wca_pkg::ID_W-1:0] id_arr [N];
  logic [N-1:0]             val_vec;
  logic [N-1:0]             hit_vec;
  logic [N-1:0]             hit_q;
  logic [N-1:0]             shift_mask;

  // holders stay packed in grant order; a removal closes the gap by
  // having every slot at or above the match take its right neighbor
  genvar k;
  for (k = 0; k < N; k++) begin : g_slot
    logic [wca_pkg::ID_W-1:0] r_id;
    logic                     r_valid;
    logic [1:0]               cop;
    if (k == N-1) begin : g_end
      assign r_id    = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_id    = id_arr[k+1];
      assign r_valid = val_vec[k+1];
    end

    always_comb begin
      unique case (ctl.op)
        wca_pkg::CH_APPEND: cop = (count == CW'(k)) ? wca_pkg::CELL_LOAD
                                                     : wca_pkg::CELL_HOLD;
        wca_pkg::CH_REMOVE: cop = shift_mask[k] ? wca_pkg::CELL_TAKE
                                                 : wca_pkg::CELL_HOLD;
        wca_pkg::CH_POP:    cop = wca_pkg::CELL_TAKE;
        wca_pkg::CH_CLEAR:  cop = wca_pkg::CELL_CLEAR;
        default:            cop = wca_pkg::CELL_HOLD;
      endcase
    end

    wca_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cop),
      .key         (ctl.key),
      .right_id    (r_id),
      .right_valid (r_valid),
      .id          (id_arr[k]),
      .valid       (val_vec[k]),
      .hit         (hit_vec[k])
    );
  end

  // log-depth prefix OR of the registered match vector
  always_comb begin
    shift_mask = hit_q;
    for (int s = 0; s < LG; s++) begin
      shift_mask = shift_mask | (shift_mask << (1 << s));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= '0;
      count <= '0;
    end else begin
      hit_q <= hit_vec;
      unique case (ctl.op)
        wca_pkg::CH_APPEND: count <= count + CW'(1);
        wca_pkg::CH_REMOVE: if (|hit_q) begin
          count <= count - CW'(1);
        end
        wca_pkg::CH_POP:    count <= count - CW'(1);
        wca_pkg::CH_CLEAR:  count <= '0;
        default:            count <= count;
      endcase
    end
  end

  assign found   = |hit_q;
  assign head_id = id_arr[0];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N)) else $error("holder count above table size");
  a_packed: assert property (@(posedge clk) disable iff (rst)
    $countones(val_vec) == int'(count)) else $error("valid slots not packed to count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.op == wca_pkg::CH_POP |-> count != '0) else $error("pop of empty row");

endmodule

FILE: hw/rtl/weighted_credit_admission_top.sv
// Credit admission for two requester classes. A command is taken when start is
// high and busy is low; busy rises the cycle after and stays high until the
// last result is registered. Each result appears for one cycle with done high
// and cannot be held off, so the receiver must take it then; last marks the
// final result of a command. Request, release, halt, board reset and unused
// commands give one result, after a look-up state in which every holder slot
// compares its id in parallel and an update state, and the next command can be
// taken in the cycle that result is shown. Revoke-all with n holders passes
// through the same look-up and update states and then gives one notice per
// cycle; the holder rows shift one slot per notice. The user must write the
// configuration registers over the APB port only while busy is low; the block
// itself does not enforce this.
module weighted_credit_admission_top #(
  parameter int HOLDERS_PER_CLASS = wca_pkg::HOLDERS_PER_CLASS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wca_pkg::APB_AW-1:0]    paddr,
  input  logic [wca_pkg::APB_DW-1:0]    pwdata,
  output logic [wca_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // commands
  input  logic                          start,
  output logic                          busy,
  input  logic [wca_pkg::CMD_W-1:0]     cmd,
  input  logic [wca_pkg::ID_W-1:0]      requester_id,
  input  logic                          requester_class,
  input  logic                          halt_value,
  // results
  output logic                          done,
  output logic                          notice_valid,
  output logic [wca_pkg::ID_W-1:0]      holder_id,
  output logic                          holder_class,
  output logic                          granted,
  output logic                          halt_flag,
  output logic [wca_pkg::CRED_W-1:0]    credits_in_use,
  output logic                          last
);

  localparam int CW = $clog2(HOLDERS_PER_CLASS + 1);
  localparam int CRW = wca_pkg::CRED_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_ACT    = 2'd2;
  localparam logic [1:0] ST_REVOKE = 2'd3;

  localparam logic [1:0] REG_SEL_LIMIT = wca_pkg::REG_CREDIT_LIMIT;
  localparam logic [1:0] REG_SEL_WA    = wca_pkg::REG_WEIGHT_A;
  localparam logic [1:0] REG_SEL_WB    = wca_pkg::REG_WEIGHT_B;

  function automatic logic [CRW-1:0] sat_sub(input logic [CRW-1:0] a,
                                            input logic [CRW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  logic [1:0]  state, state_next;
  logic [CRW-1:0] credit_limit, weight_a, weight_b;
  logic [CRW-1:0] used, used_next;
  logic           halt, halt_next;

  logic [wca_pkg::CMD_W-1:0] cmd_q;
  logic [wca_pkg::ID_W-1:0]  id_q;
  logic                      cls_q;
  logic                      hv_q;

  wca_pkg::chain_ctl_t ctl_a, ctl_b;
  logic [2:0]          op_a, op_b;
  logic [CW-1:0]       cnt_a, cnt_b;
  logic                found_a, found_b;
  logic [wca_pkg::ID_W-1:0] head_a, head_b;

  logic                      res_fire, res_notice, res_cls, res_grant, res_last;
  logic [wca_pkg::ID_W-1:0]  res_id;

  logic [CRW-1:0] w_sel;
  logic [CW-1:0]  cnt_sel;
  logic           found_sel, fits;
  logic [CW:0]    remaining;

  // APB
  logic wr_en;
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_SEL_LIMIT: prdata = {{(wca_pkg::APB_DW-CRW){1'b0}}, credit_limit};
      REG_SEL_WA:    prdata = {{(wca_pkg::APB_DW-CRW){1'b0}}, weight_a};
      REG_SEL_WB:    prdata = {{(wca_pkg::APB_DW-CRW){1'b0}}, weight_b};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_limit <= '0;
      weight_a     <= '0;
      weight_b     <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SEL_LIMIT: credit_limit <= pwdata[CRW-1:0];
        REG_SEL_WA:    weight_a     <= pwdata[CRW-1:0];
        REG_SEL_WB:    weight_b     <= pwdata[CRW-1:0];
        default:       ;
      endcase
    end
  end

  // holder rows
  assign ctl_a.op  = op_a;
  assign ctl_a.key = id_q;
  assign ctl_b.op  = op_b;
  assign ctl_b.key = id_q;

  wca_chain #(.N(HOLDERS_PER_CLASS)) u_chain_a (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_a),
    .count   (cnt_a),
    .found   (found_a),
    .head_id (head_a)
  );

  wca_chain #(.N(HOLDERS_PER_CLASS)) u_chain_b (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_b),
    .count   (cnt_b),
    .found   (found_b),
    .head_id (head_b)
  );

  assign busy      = (state != ST_IDLE);
  assign w_sel     = cls_q ? weight_b : weight_a;
  assign cnt_sel   = cls_q ? cnt_b : cnt_a;
  assign found_sel = cls_q ? found_b : found_a;
  assign fits      = (used <= credit_limit) && ((credit_limit - used) >= w_sel)
                     && (cnt_sel < CW'(HOLDERS_PER_CLASS));
  assign remaining = {1'b0, cnt_a} + {1'b0, cnt_b};

  always_comb begin
    state_next = state;
    used_next  = used;
    halt_next  = halt;
    op_a       = wca_pkg::CH_HOLD;
    op_b       = wca_pkg::CH_HOLD;
    res_fire   = 1'b0;
    res_notice = 1'b0;
    res_id     = '0;
    res_cls    = 1'b0;
    res_grant  = 1'b0;
    res_last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: state_next = ST_ACT;
      ST_ACT: begin
        res_fire   = 1'b1;
        state_next = ST_IDLE;
        unique case (cmd_q)
          wca_pkg::CMD_REQUEST: begin
            res_notice = 1'b1;
            res_id     = id_q;
            res_cls    = cls_q;
            if (found_sel) begin
              res_grant = 1'b1;
            end else if (fits) begin
              res_grant = 1'b1;
              used_next = used + w_sel;
              if (cls_q) begin
                op_b = wca_pkg::CH_APPEND;
              end else begin
                op_a = wca_pkg::CH_APPEND;
              end
            end
          end
          wca_pkg::CMD_RELEASE: begin
            if (found_sel) begin
              used_next = sat_sub(used, w_sel);
              if (cls_q) begin
                op_b = wca_pkg::CH_REMOVE;
              end else begin
                op_a = wca_pkg::CH_REMOVE;
              end
            end
          end
          wca_pkg::CMD_REVOKE: begin
            if (remaining != '0) begin
              res_fire   = 1'b0;
              state_next = ST_REVOKE;
            end
          end
          wca_pkg::CMD_RESET: begin
            op_a      = wca_pkg::CH_CLEAR;
            op_b      = wca_pkg::CH_CLEAR;
            used_next = '0;
            halt_next = 1'b0;
          end
          wca_pkg::CMD_HALT: halt_next = hv_q;
          default: ;
        endcase
      end
      ST_REVOKE: begin
        // class A holders first, then class B, each in grant order
        res_fire   = 1'b1;
        res_notice = 1'b1;
        res_last   = (remaining == (CW+1)'(1));
        if (cnt_a != '0) begin
          op_a      = wca_pkg::CH_POP;
          res_id    = head_a;
          res_cls   = 1'b0;
          used_next = sat_sub(used, weight_a);
        end else begin
          op_b      = wca_pkg::CH_POP;
          res_id    = head_b;
          res_cls   = 1'b1;
          used_next = sat_sub(used, weight_b);
        end
        if (res_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      halt  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      halt  <= halt_next;
      done  <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_q <= cmd;
      id_q  <= requester_id;
      cls_q <= requester_class;
      hv_q  <= halt_value;
    end
    if (res_fire) begin
      notice_valid   <= res_notice;
      holder_id      <= res_id;
      holder_class   <= res_cls;
      granted        <= res_grant;
      halt_flag      <= halt_next;
      credits_in_use <= used_next;
      last           <= res_last;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command taken but block not busy");
  a_revoke_stream: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done) else $error("gap inside revoke notice stream");
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    done && !notice_valid |-> last) else $error("status result not final");
  a_result_only_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy) else $error("more notices pending while idle");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int H           = wca_pkg::HOLDERS_PER_CLASS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_N      = 40;
  localparam int PHASE_ITEMS = 59;

  // commands the block takes but does nothing with
  localparam logic [wca_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [wca_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                       nv;
    logic [wca_pkg::ID_W-1:0]   id;
    logic                       cls;
    logic                       gr;
    logic                       halt;
    logic [wca_pkg::CRED_W-1:0] cred;
    logic                       last;
  } notice_t;

  class admission_board;
    logic [wca_pkg::CRED_W-1:0] limit;
    logic [wca_pkg::CRED_W-1:0] weight[2];
    logic [wca_pkg::CRED_W-1:0] used;
    logic [wca_pkg::ID_W-1:0]   holders[2][H];
    int                         count[2];
    logic                       halt;
    notice_t                    pending[$];
    int errors, results, grants, denials, revoked, longest;

    function new();
      limit = '0;
      weight[0] = '0;
      weight[1] = '0;
      used = '0;
      halt = 1'b0;
      errors = 0;
      results = 0;
      grants = 0;
      denials = 0;
      revoked = 0;
      longest = 0;
      wipe();
    endfunction

    function void wipe();
      for (int c = 0; c < 2; c++) begin
        count[c] = 0;
        for (int i = 0; i < H; i++) holders[c][i] = '0;
      end
    endfunction

    function logic [wca_pkg::CRED_W-1:0] drain_credits(logic [wca_pkg::CRED_W-1:0] w);
      return (used > w) ? used - w : '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [wca_pkg::CRED_W-1:0] val);
      case (idx)
        wca_pkg::REG_CREDIT_LIMIT: limit = val;
        wca_pkg::REG_WEIGHT_A:     weight[0] = val;
        wca_pkg::REG_WEIGHT_B:     weight[1] = val;
        default: ;
      endcase
    endfunction

    function void push(logic nv, logic [wca_pkg::ID_W-1:0] id, logic cls, logic gr,
                       logic is_last);
      notice_t n;
      n.nv   = nv;
      n.id   = id;
      n.cls  = cls;
      n.gr   = gr;
      n.halt = halt;
      n.cred = used;
      n.last = is_last;
      pending = {pending, n};
    endfunction

    // works out every result that one accepted request will produce
    function void note(logic [wca_pkg::CMD_W-1:0] c, logic [wca_pkg::ID_W-1:0] id, logic cls,
                       logic hv);
      int  hit;
      int  total;
      int  k;
      logic gr;
      hit = -1;
      for (int i = 0; i < count[cls]; i++)
        if (hit < 0 && holders[cls][i] == id) hit = i;
      case (c)
        wca_pkg::CMD_REQUEST: begin
          gr = (hit >= 0);
          if (!gr && used <= limit && limit - used >= weight[cls] && count[cls] < H) begin
            holders[cls][count[cls]] = id;
            count[cls]++;
            used = used + weight[cls];
            gr = 1'b1;
          end
          if (gr) grants++;
          else denials++;
          push(1'b1, id, cls, gr, 1'b1);
        end
        wca_pkg::CMD_RELEASE: begin
          if (hit >= 0) begin
            for (int j = hit; j + 1 < count[cls]; j++) holders[cls][j] = holders[cls][j + 1];
            count[cls]--;
            holders[cls][count[cls]] = '0;
            used = drain_credits(weight[cls]);
          end
          push(1'b0, '0, 1'b0, 1'b0, 1'b1);
        end
        wca_pkg::CMD_REVOKE: begin
          total = count[0] + count[1];
          if (total == 0) begin
            push(1'b0, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            k = 0;
            // class A in grant order, then class B
            for (int cc = 0; cc < 2; cc++)
              for (int i = 0; i < count[cc]; i++) begin
                used = drain_credits(weight[cc]);
                k++;
                push(1'b1, holders[cc][i], cc[0], 1'b0, k == total);
              end
            revoked += total;
            if (total > longest) longest = total;
            wipe();
          end
        end
        wca_pkg::CMD_RESET: begin
          used = '0;
          halt = 1'b0;
          wipe();
          push(1'b0, '0, 1'b0, 1'b0, 1'b1);
        end
        wca_pkg::CMD_HALT: begin
          halt = hv;
          push(1'b0, '0, 1'b0, 1'b0, 1'b1);
        end
        default: push(1'b0, '0, 1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check(notice_t got);
      notice_t want;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with nothing pending: %h", results, got));
        return;
      end
      want = pending.pop_front();
      if (got.nv !== want.nv)
        report($sformatf("result %0d notice_valid %b, want %b", results, got.nv, want.nv));
      if (got.id !== want.id)
        report($sformatf("result %0d holder_id %h, want %h", results, got.id, want.id));
      if (got.cls !== want.cls)
        report($sformatf("result %0d holder_class %b, want %b", results, got.cls, want.cls));
      if (got.gr !== want.gr)
        report($sformatf("result %0d granted %b, want %b", results, got.gr, want.gr));
      if (got.halt !== want.halt)
        report($sformatf("result %0d halt_flag %b, want %b", results, got.halt, want.halt));
      if (got.cred !== want.cred)
        report($sformatf("result %0d credits_in_use %0d, want %0d", results, got.cred,
                         want.cred));
      if (got.last !== want.last)
        report($sformatf("result %0d last %b, want %b", results, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [wca_pkg::APB_AW-1:0] paddr;
  logic [wca_pkg::APB_DW-1:0] pwdata;
  logic [wca_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic start, busy;
  logic [wca_pkg::CMD_W-1:0] cmd;
  logic [wca_pkg::ID_W-1:0] requester_id;
  logic requester_class, halt_value;
  logic done, notice_valid, holder_class, granted, halt_flag, last;
  logic [wca_pkg::ID_W-1:0] holder_id;
  logic [wca_pkg::CRED_W-1:0] credits_in_use;

  admission_board board;
  int cycles = 0;
  int sent = 0;
  int writes = 0;
  int settings = 0;
  bit burst = 1'b0;
  logic [wca_pkg::ID_W-1:0] pool[POOL_N];

  weighted_credit_admission_top dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .requester_id(requester_id),
    .requester_class(requester_class),
    .halt_value(halt_value),
    .done(done),
    .notice_valid(notice_valid),
    .holder_id(holder_id),
    .holder_class(holder_class),
    .granted(granted),
    .halt_flag(halt_flag),
    .credits_in_use(credits_in_use),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               board.pending.size());
      $display("weighted_credit_admission_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      board.check(notice_t'({notice_valid, holder_id, holder_class, granted, halt_flag,
                             credits_in_use, last}));
  end

  function automatic int draw_gap();
    if (burst) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // start stays high across back-to-back requests; busy blocks the second copy
  task automatic issue(logic [wca_pkg::CMD_W-1:0] c, logic [wca_pkg::ID_W-1:0] id, logic cls,
                       logic hv, int gap);
    cmd             <= c;
    requester_id    <= id;
    requester_class <= cls;
    halt_value      <= hv;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    board.note(c, id, cls, hv);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [wca_pkg::CRED_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wca_pkg::APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [wca_pkg::CRED_W-1:0] lim, logic [wca_pkg::CRED_W-1:0] wa,
                           logic [wca_pkg::CRED_W-1:0] wb);
    settle();
    write_reg(wca_pkg::REG_CREDIT_LIMIT, lim);
    write_reg(wca_pkg::REG_WEIGHT_A, wa);
    write_reg(wca_pkg::REG_WEIGHT_B, wb);
    settings++;
  endtask

  task automatic random_item(int req_pct);
    int r;
    logic [wca_pkg::CMD_W-1:0] c;
    logic [wca_pkg::ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < req_pct) begin
      c = wca_pkg::CMD_REQUEST;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) c = wca_pkg::CMD_RELEASE;
      else if (r < 62) c = wca_pkg::CMD_HALT;
      else if (r < 76) c = wca_pkg::CMD_REVOKE;
      else if (r < 86) c = wca_pkg::CMD_RESET;
      else c = wca_pkg::CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
    // mostly a small set of ids so releases and repeats hit holders
    id = ($urandom_range(0, 4) == 0) ? wca_pkg::ID_W'($urandom)
                                     : pool[$urandom_range(0, POOL_N - 1)];
    issue(c, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), draw_gap());
  endtask

  initial begin
    board = new();
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    start           <= 1'b0;
    cmd             <= wca_pkg::CMD_REQUEST;
    requester_id    <= '0;
    requester_class <= 1'b0;
    halt_value      <= 1'b0;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) pool[i] = wca_pkg::ID_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty revoke, zero weights, exact fit, regrant, both classes
    issue(wca_pkg::CMD_REVOKE, 16'h0000, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_REQUEST, 16'h0000, 1'b0, 1'b0, 2);
    configure(8'd255, 8'd100, 8'd155);
    issue(wca_pkg::CMD_REQUEST, 16'hFFFF, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_REQUEST, 16'hFFFF, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_REQUEST, 16'hFFFF, 1'b1, 1'b0, 3);
    issue(wca_pkg::CMD_REQUEST, 16'h1234, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_RELEASE, 16'h5555, 1'b0, 1'b0, 1);
    issue(wca_pkg::CMD_HALT, 16'h0000, 1'b0, 1'b1, 0);
    issue(CMD_SPARE_LO, 16'hFFFF, 1'b1, 1'b1, 0);
    issue(wca_pkg::CMD_REQUEST, 16'h0000, 1'b0, 1'b0, 5);
    issue(CMD_SPARE_HI, 16'hA5A5, 1'b1, 1'b0, 0);
    issue(wca_pkg::CMD_HALT, 16'h0000, 1'b0, 1'b0, 0);
    // limit lowered under the credits held, then revoke leaves a remainder
    configure(8'd50, 8'd20, 8'd155);
    issue(wca_pkg::CMD_REQUEST, 16'h0001, 1'b1, 1'b0, 0);
    issue(wca_pkg::CMD_REVOKE, 16'h0000, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_REQUEST, 16'h0002, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_RESET, 16'hFFFF, 1'b1, 1'b1, 2);
    configure(8'd255, 8'd5, 8'd0);
    issue(wca_pkg::CMD_REQUEST, 16'h0009, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_REQUEST, 16'h0009, 1'b1, 1'b0, 0);
    // weight raised after the grant: refund saturates
    configure(8'd255, 8'd200, 8'd0);
    issue(wca_pkg::CMD_RELEASE, 16'h0009, 1'b0, 1'b0, 0);
    issue(wca_pkg::CMD_RELEASE, 16'h0009, 1'b1, 1'b0, 0);
    issue(wca_pkg::CMD_HALT, 16'h0000, 1'b0, 1'b1, 0);
    issue(wca_pkg::CMD_REVOKE, 16'h0000, 1'b0, 1'b0, 1);
    issue(wca_pkg::CMD_RESET, 16'h0000, 1'b0, 1'b0, 0);

    // fill both tables past capacity, then revoke every holder
    configure(8'd255, 8'd0, 8'd0);
    burst = ($urandom_range(0, 1) == 0);
    for (int k = 0; k <= H; k++) begin
      issue(wca_pkg::CMD_REQUEST, pool[k], 1'b0, 1'($urandom_range(0, 1)), draw_gap());
      issue(wca_pkg::CMD_REQUEST, pool[POOL_N - 1 - k], 1'b1, 1'($urandom_range(0, 1)),
            draw_gap());
    end
    issue(wca_pkg::CMD_REVOKE, wca_pkg::ID_W'($urandom), 1'b0, 1'b0, draw_gap());

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: configure(8'd255, 8'd1, 8'd1);
        2: configure(8'd0, 8'd0, 8'd0);
        3: configure(8'd255, 8'd255, 8'd255);
        4: configure(8'd40, 8'd3, 8'd7);
        5: configure(8'd20, 8'd255, 8'd1);
        6: configure(wca_pkg::CRED_W'($urandom), wca_pkg::CRED_W'($urandom),
                     wca_pkg::CRED_W'($urandom));
        default: configure(wca_pkg::CRED_W'($urandom_range(100, 255)),
                           wca_pkg::CRED_W'($urandom_range(0, 15)),
                           wca_pkg::CRED_W'($urandom_range(0, 15)));
      endcase
      burst = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) random_item((p == 1) ? 75 : 60);
    end

    settle();
    repeat (16) @(posedge clk);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending.size()));
    $display("ran %0d requests through %0d settings (%0d register writes), %0d results seen",
             sent, settings, writes, board.results);
    $display("%0d grants, %0d denials, %0d holders revoked, largest revoke %0d holders",
             board.grants, board.denials, board.revoked, board.longest);
    if (board.errors == 0) begin
      $display("weighted_credit_admission_top: match");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("weighted_credit_admission_top: mismatch");
    end
    $finish;
  end

endmodule
